### hdl/ccpw_pkg.sv
// shared types, constants and cube helpers for the color cube path walker
package ccpw_pkg;

  // palette range of the 6x6x6 cube
  localparam int unsigned CubeBase   = 16;
  localparam int unsigned CubeTop    = 231;
  localparam int unsigned CubeSide   = 6;
  localparam int unsigned MaxResults = 16;

  localparam int unsigned IdxW   = 8;
  localparam int unsigned CoordW = 3;
  localparam int unsigned DistW  = 16;
  localparam int unsigned CntW   = $clog2(MaxResults + 1);

  // walk mode codes (any other code walks the line)
  localparam logic [1:0] ModeLine  = 2'd0;
  localparam logic [1:0] ModeYarn  = 2'd1;
  localparam logic [1:0] ModeEdges = 2'd2;

  // axis order codes
  localparam logic [2:0] OrdRgb = 3'd0;
  localparam logic [2:0] OrdRbg = 3'd1;
  localparam logic [2:0] OrdGrb = 3'd2;
  localparam logic [2:0] OrdGbr = 3'd3;
  localparam logic [2:0] OrdBrg = 3'd4;
  localparam logic [2:0] OrdBgr = 3'd5;

  // axis numbers
  localparam logic [1:0] AxR = 2'd0;
  localparam logic [1:0] AxG = 2'd1;
  localparam logic [1:0] AxB = 2'd2;

  typedef logic [CoordW-1:0] coord_t;
  // element 0 is r, 1 is g, 2 is b
  typedef coord_t [2:0] cell_t;

  // registered result of the shared distance unit
  typedef struct packed {
    logic              valid;
    cell_t             pos;
    logic [DistW-1:0]  dist_sq;
  } cross_res_t;

  // split a palette index into cube coordinates by compare chains
  function automatic cell_t to_cell(input logic [IdxW-1:0] idx);
    logic [IdxW-1:0] n;
    logic [IdxW-1:0] rem;
    cell_t           c;
    n    = idx - IdxW'(CubeBase);
    c    = '0;
    for (int k = 1; k < CubeSide; k++) begin
      if (n >= IdxW'(CubeSide * CubeSide * k)) c[0] = CoordW'(k);
    end
    rem  = n - IdxW'(CubeSide * CubeSide * int'(c[0]));
    for (int k = 1; k < CubeSide; k++) begin
      if (rem >= IdxW'(CubeSide * k)) c[1] = CoordW'(k);
    end
    rem  = rem - IdxW'(CubeSide * int'(c[1]));
    c[2] = CoordW'(rem);
    return c;
  endfunction

  // palette index of a cube cell
  function automatic logic [IdxW-1:0] to_index(input cell_t c);
    return IdxW'(CubeSide * CubeSide * int'(c[0]) + CubeSide * int'(c[1])
                 + int'(c[2]) + CubeBase);
  endfunction

  // axis walked at a given stage of an axis order
  function automatic logic [1:0] axis_at(input logic [2:0] ord, input logic [1:0] stage);
    logic [1:0] a0;
    logic [1:0] a1;
    logic [1:0] a2;
    case (ord)
      OrdRbg:  begin a0 = AxR; a1 = AxB; a2 = AxG; end
      OrdGrb:  begin a0 = AxG; a1 = AxR; a2 = AxB; end
      OrdGbr:  begin a0 = AxG; a1 = AxB; a2 = AxR; end
      OrdBrg:  begin a0 = AxB; a1 = AxR; a2 = AxG; end
      OrdBgr:  begin a0 = AxB; a1 = AxG; a2 = AxR; end
      default: begin a0 = AxR; a1 = AxG; a2 = AxB; end
    endcase
    case (stage)
      2'd0:    return a0;
      2'd1:    return a1;
      default: return a2;
    endcase
  endfunction

endpackage

### hdl/ccpw_cross.sv
// shared distance unit: squared cross product norm of a candidate against the line
module ccpw_cross (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cand_valid_i,
  input  ccpw_pkg::cell_t      cand_i,
  input  ccpw_pkg::cell_t      from_i,
  input  ccpw_pkg::cell_t      to_i,
  output ccpw_pkg::cross_res_t res_o
);
  import ccpw_pkg::*;

  logic signed [3:0] l, m, n, x, y, z;
  logic signed [7:0] ti, tj, tk;
  logic signed [7:0] ti_q, tj_q, tk_q;
  logic              valid_q;
  cell_t             cell_q;
  logic signed [15:0] si, sj, sk;

  // line vector and candidate offset from the start
  assign l = $signed({1'b0, to_i[0]}) - $signed({1'b0, from_i[0]});
  assign m = $signed({1'b0, to_i[1]}) - $signed({1'b0, from_i[1]});
  assign n = $signed({1'b0, to_i[2]}) - $signed({1'b0, from_i[2]});
  assign x = $signed({1'b0, cand_i[0]}) - $signed({1'b0, from_i[0]});
  assign y = $signed({1'b0, cand_i[1]}) - $signed({1'b0, from_i[1]});
  assign z = $signed({1'b0, cand_i[2]}) - $signed({1'b0, from_i[2]});

  // cross product terms
  assign ti = 8'(x * m) - 8'(y * l);
  assign tj = 8'(y * n) - 8'(z * m);
  assign tk = 8'(z * l) - 8'(x * n);

  // stage register between the products and the squares
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      cell_q  <= '0;
      ti_q    <= '0;
      tj_q    <= '0;
      tk_q    <= '0;
    end else begin
      valid_q <= cand_valid_i;
      cell_q  <= cand_i;
      ti_q    <= ti;
      tj_q    <= tj;
      tk_q    <= tk;
    end
  end

  // squared norm
  assign si = 16'(ti_q * ti_q);
  assign sj = 16'(tj_q * tj_q);
  assign sk = 16'(tk_q * tk_q);

  assign res_o.valid   = valid_q;
  assign res_o.pos     = cell_q;
  assign res_o.dist_sq = DistW'($unsigned(si) + $unsigned(sj) + $unsigned(sk));

endmodule

### hdl/color_cube_path_walker_unit.sv
// top level: request intake, walk sequencer and result output of the path walker
//
// One request enters on the s_axis channel (start index, end index, walk mode,
// axis order) and yields one to 16 path cells on the m_axis channel, the start
// cell first; tlast marks the final cell of the run and tuser flags a request
// whose index lies outside 16..231 (a single cell of index 0 then).
// s_axis_tready is high only while the walker is idle, so one request is in
// work at a time; the next one is taken as soon as the final cell sits in the
// output register, even if the receiver has not taken it yet.
// Order of work: the request is decoded, then each line step runs a check, seven
// candidates through the shared distance unit, a pipeline drain and an apply;
// the edge state emits axis edge cells one at a time and moves on to the next
// axis in a separate step. A cell is held in a pending register until it is
// known whether another follows, so the start cell moves to the output
// register only when the next cell is pushed or the run is flushed. When the
// receiver stalls, the output and pending registers fill and the sequencer
// waits; nothing is dropped.
// Reset clears the sequencer and both valid flags; no clearing pass is needed.
module color_cube_path_walker_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // start_color, end_color, walk_mode, axis_order
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // color_index
  output logic        m_axis_tlast,   // last_cell
  output logic        m_axis_tuser    // bad_request
);
  import ccpw_pkg::*;

  typedef enum logic [2:0] {
    StIdle, StDecode, StLineChk, StScan, StDrain, StApply, StEdge, StFinish
  } state_e;

  state_e          state_q, state_d;
  logic [IdxW-1:0] start_q, start_d, end_q, end_d;
  logic [1:0]      mode_q, mode_d;
  logic [2:0]      ord_q, ord_d;
  cell_t           f_q, f_d, t_q, t_d, c_q, c_d, w_q, w_d, goal_q, goal_d, best_q, best_d;
  logic [1:0]      stage_q, stage_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [2:0]      cand_q, cand_d;
  logic [DistW-1:0] best_dist_q, best_dist_d;
  logic            found_q, found_d;
  logic [IdxW-1:0] pend_idx_q, pend_idx_d, out_idx_q, out_idx_d;
  logic            pend_bad_q, pend_bad_d, out_bad_q, out_bad_d;
  logic            pend_v_q, pend_v_d, out_v_q, out_v_d, out_last_q, out_last_d;

  logic            push, flush, can_push, out_free, bad_req, cnt_full;
  logic [IdxW-1:0] push_idx;
  logic            push_bad;
  logic [1:0]      ax;
  cell_t           w_step, cand;
  logic [2:0]      cand_ok;
  logic            cand_valid;
  cross_res_t      res;

  assign out_free = !out_v_q || m_axis_tready;
  assign can_push = !pend_v_q || out_free;
  assign cnt_full = (cnt_q == CntW'(MaxResults));
  assign bad_req  = (start_q < IdxW'(CubeBase)) || (start_q > IdxW'(CubeTop)) ||
                    (end_q < IdxW'(CubeBase)) || (end_q > IdxW'(CubeTop));

  // line candidate from the scan index: r outermost, b innermost
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      cand[a]    = c_q[a];
      cand_ok[a] = 1'b1;
      if (cand_q[2 - a]) begin
        if (t_q[a] == f_q[a]) begin
          cand_ok[a] = 1'b0;
        end else if (t_q[a] > f_q[a]) begin
          cand_ok[a] = (c_q[a] != CoordW'(CubeSide - 1));
          cand[a]    = c_q[a] + CoordW'(1);
        end else begin
          cand_ok[a] = (c_q[a] != '0);
          cand[a]    = c_q[a] - CoordW'(1);
        end
      end
    end
    cand_valid = (state_q == StScan) && (&cand_ok);
  end

  ccpw_cross u_cross (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cand_valid_i (cand_valid),
    .cand_i       (cand),
    .from_i       (f_q),
    .to_i         (t_q),
    .res_o        (res)
  );

  // one step of the edge walk on the current axis
  assign ax = axis_at(ord_q, stage_q);
  always_comb begin
    w_step = w_q;
    if (goal_q[ax] > w_q[ax]) w_step[ax] = w_q[ax] + CoordW'(1);
    else                      w_step[ax] = w_q[ax] - CoordW'(1);
  end

  // walk sequencer
  always_comb begin
    state_d     = state_q;
    start_d     = start_q;
    end_d       = end_q;
    mode_d      = mode_q;
    ord_d       = ord_q;
    f_d         = f_q;
    t_d         = t_q;
    c_d         = c_q;
    w_d         = w_q;
    goal_d      = goal_q;
    best_d      = best_q;
    stage_d     = stage_q;
    cnt_d       = cnt_q;
    cand_d      = cand_q;
    best_dist_d = best_dist_q;
    found_d     = found_q;
    push        = 1'b0;
    push_idx    = '0;
    push_bad    = 1'b0;
    flush       = 1'b0;

    case (state_q)
      StIdle: begin
        if (s_axis_tvalid) begin
          start_d = s_axis_tdata[7:0];
          end_d   = s_axis_tdata[15:8];
          mode_d  = s_axis_tdata[17:16];
          ord_d   = s_axis_tdata[20:18];
          state_d = StDecode;
        end
      end
      StDecode: begin
        if (can_push) begin
          push = 1'b1;
          if (bad_req) begin
            push_bad = 1'b1;
            state_d  = StFinish;
          end else begin
            push_idx = start_q;
            f_d      = to_cell(start_q);
            t_d      = to_cell(end_q);
            c_d      = f_d;
            w_d      = f_d;
            goal_d   = t_d;
            stage_d  = '0;
            cnt_d    = CntW'(1);
            state_d  = (mode_q == ModeEdges) ? StEdge : StLineChk;
          end
        end
      end
      StLineChk: begin
        if (c_q == t_q || cnt_full) begin
          state_d = StFinish;
        end else begin
          found_d = 1'b0;
          cand_d  = 3'd1;
          state_d = StScan;
        end
      end
      StScan: begin
        cand_d = cand_q + 3'd1;
        if (cand_q == 3'd7) state_d = StDrain;
      end
      StDrain: begin
        state_d = StApply;
      end
      StApply: begin
        if (!found_q) begin
          state_d = StFinish;
        end else if (mode_q == ModeYarn) begin
          w_d     = c_q;
          goal_d  = best_q;
          c_d     = best_q;
          stage_d = '0;
          state_d = StEdge;
        end else if (can_push) begin
          c_d      = best_q;
          push     = 1'b1;
          push_idx = to_index(best_q);
          cnt_d    = cnt_q + CntW'(1);
          state_d  = StLineChk;
        end
      end
      StEdge: begin
        if (!cnt_full && w_q[ax] != goal_q[ax]) begin
          if (can_push) begin
            w_d      = w_step;
            push     = 1'b1;
            push_idx = to_index(w_step);
            cnt_d    = cnt_q + CntW'(1);
          end
        end else if (!cnt_full && stage_q != 2'd2) begin
          stage_d = stage_q + 2'd1;
        end else begin
          state_d = (mode_q == ModeEdges) ? StFinish : StLineChk;
        end
      end
      StFinish: begin
        if (out_free) begin
          flush   = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase

    // keep the nearest candidate, first in scan order on a tie
    if (res.valid && (!found_q || res.dist_sq < best_dist_q)) begin
      found_d     = 1'b1;
      best_dist_d = res.dist_sq;
      best_d      = res.pos;
    end
  end

  // pending cell and output register
  always_comb begin
    pend_v_d   = pend_v_q;
    pend_idx_d = pend_idx_q;
    pend_bad_d = pend_bad_q;
    out_v_d    = out_v_q && !m_axis_tready;
    out_idx_d  = out_idx_q;
    out_bad_d  = out_bad_q;
    out_last_d = out_last_q;
    if (push) begin
      if (pend_v_q) begin
        out_v_d    = 1'b1;
        out_idx_d  = pend_idx_q;
        out_bad_d  = pend_bad_q;
        out_last_d = 1'b0;
      end
      pend_v_d   = 1'b1;
      pend_idx_d = push_idx;
      pend_bad_d = push_bad;
    end
    if (flush) begin
      out_v_d    = 1'b1;
      out_idx_d  = pend_idx_q;
      out_bad_d  = pend_bad_q;
      out_last_d = 1'b1;
      pend_v_d   = 1'b0;
    end
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      start_q     <= '0;
      end_q       <= '0;
      mode_q      <= ModeLine;
      ord_q       <= OrdRgb;
      f_q         <= '0;
      t_q         <= '0;
      c_q         <= '0;
      w_q         <= '0;
      goal_q      <= '0;
      best_q      <= '0;
      stage_q     <= '0;
      cnt_q       <= '0;
      cand_q      <= '0;
      best_dist_q <= '0;
      found_q     <= 1'b0;
      pend_v_q    <= 1'b0;
      pend_idx_q  <= '0;
      pend_bad_q  <= 1'b0;
      out_v_q     <= 1'b0;
      out_idx_q   <= '0;
      out_bad_q   <= 1'b0;
      out_last_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      start_q     <= start_d;
      end_q       <= end_d;
      mode_q      <= mode_d;
      ord_q       <= ord_d;
      f_q         <= f_d;
      t_q         <= t_d;
      c_q         <= c_d;
      w_q         <= w_d;
      goal_q      <= goal_d;
      best_q      <= best_d;
      stage_q     <= stage_d;
      cnt_q       <= cnt_d;
      cand_q      <= cand_d;
      best_dist_q <= best_dist_d;
      found_q     <= found_d;
      pend_v_q    <= pend_v_d;
      pend_idx_q  <= pend_idx_d;
      pend_bad_q  <= pend_bad_d;
      out_v_q     <= out_v_d;
      out_idx_q   <= out_idx_d;
      out_bad_q   <= out_bad_d;
      out_last_q  <= out_last_d;
    end
  end

  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_idx_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_bad_q;

endmodule

### tb/color_cube_path_walker_unit_tb.sv
// self-checking testbench for the color cube path walker: random and directed path requests
module color_cube_path_walker_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ccpw_pkg::*;

  // one expected path cell
  typedef struct packed {
    logic [7:0] color;
    logic       last;
    logic       bad;
  } path_cell_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata  = '0;  // start_color, end_color, walk_mode, axis_order
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;        // color_index
  logic        m_axis_tlast;        // last_cell
  logic        m_axis_tuser;        // bad_request

  logic [23:0] request_q [$];
  path_cell_t  cell_q [$];
  logic [7:0]  run_cells [$];
  int          mismatch_cnt = 0;
  int          cycle_cnt    = 0;

  // walk state of the path predictor
  int          src_p [3];
  int          dst_p [3];
  int          dir_p [3];
  int          cur_p [3];
  int          pen_p [3];
  logic [2:0]  walk_ord;

  color_cube_path_walker_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) cycle_cnt <= cycle_cnt + 1;

  // random idle cycle, none inside the quiet window
  function automatic bit roll_idle();
    if (cycle_cnt >= 2000 && cycle_cnt < 8000) return 1'b0;
    return $urandom_range(99) < 6;
  endfunction

  // append a cube cell to the run, capped at the result limit
  function automatic void add_cell(input int r, input int g, input int b);
    if (run_cells.size() < MaxResults)
      run_cells.insert(run_cells.size(), 8'(36 * r + 6 * g + b + 16));
  endfunction

  // axis walked at stage s of an axis order; unknown orders fall back to rgb
  function automatic int axis_of(input logic [2:0] ord, input int s);
    logic [5:0] seq;
    case (ord)
      OrdRbg:  seq = {AxG, AxB, AxR};
      OrdGrb:  seq = {AxB, AxR, AxG};
      OrdGbr:  seq = {AxR, AxB, AxG};
      OrdBrg:  seq = {AxG, AxR, AxB};
      OrdBgr:  seq = {AxR, AxG, AxB};
      default: seq = {AxB, AxG, AxR};
    endcase
    return int'(seq[2*s +: 2]);
  endfunction

  // move the pen axis by axis to the target, emitting every cell passed
  function automatic void walk_edges(input int tr, input int tg, input int tb);
    int tgt [3];
    int a;
    tgt[0] = tr;
    tgt[1] = tg;
    tgt[2] = tb;
    for (int s = 0; s < 3; s++) begin
      a = axis_of(walk_ord, s);
      while (pen_p[a] != tgt[a] && run_cells.size() < MaxResults) begin
        pen_p[a] += (tgt[a] > pen_p[a]) ? 1 : -1;
        add_cell(pen_p[0], pen_p[1], pen_p[2]);
      end
    end
  endfunction

  // squared norm of (cell - start) x (end - start)
  function automatic int cross_norm(input int qr, input int qg, input int qb);
    int l, m, n, x, y, z, i, j, k;
    l = dst_p[0] - src_p[0];
    m = dst_p[1] - src_p[1];
    n = dst_p[2] - src_p[2];
    x = qr - src_p[0];
    y = qg - src_p[1];
    z = qb - src_p[2];
    i = x * m - y * l;
    j = y * n - z * m;
    k = z * l - x * n;
    return i * i + j * j + k * k;
  endfunction

  // one line step: nearest in-cube candidate, first in scan order on a tie
  function automatic void line_step();
    int best_r, best_g, best_b, best_d, norm_v, qr, qg, qb;
    bit found;
    found  = 1'b0;
    best_d = 0;
    best_r = cur_p[0];
    best_g = cur_p[1];
    best_b = cur_p[2];
    for (int i = 0; i < 2; i++) begin
      for (int j = 0; j < 2; j++) begin
        for (int k = 0; k < 2; k++) begin
          if (i + j + k == 0) continue;
          if ((i && dir_p[0] == 0) || (j && dir_p[1] == 0) || (k && dir_p[2] == 0)) continue;
          qr = cur_p[0] + i * dir_p[0];
          qg = cur_p[1] + j * dir_p[1];
          qb = cur_p[2] + k * dir_p[2];
          if (qr < 0 || qr > 5 || qg < 0 || qg > 5 || qb < 0 || qb > 5) continue;
          norm_v = cross_norm(qr, qg, qb);
          if (!found || norm_v < best_d) begin
            best_d = norm_v;
            best_r = qr;
            best_g = qg;
            best_b = qb;
            found  = 1'b1;
          end
        end
      end
    end
    cur_p[0] = best_r;
    cur_p[1] = best_g;
    cur_p[2] = best_b;
  endfunction

  // expected path cells of one accepted request
  function automatic void walk_path(input logic [23:0] req);
    logic [7:0] s_idx, e_idx;
    logic [1:0] mode;
    int         sn, en, prev [3];
    path_cell_t pc;
    s_idx    = req[7:0];
    e_idx    = req[15:8];
    mode     = req[17:16];
    walk_ord = req[20:18];
    if (s_idx < CubeBase || s_idx > CubeTop || e_idx < CubeBase || e_idx > CubeTop) begin
      pc = '{color: 8'd0, last: 1'b1, bad: 1'b1};
      cell_q.insert(cell_q.size(), pc);
      return;
    end
    if (walk_ord > OrdBgr) walk_ord = OrdRgb;
    sn = int'(s_idx) - 16;
    en = int'(e_idx) - 16;
    src_p[0] = sn / 36;
    src_p[1] = (sn / 6) % 6;
    src_p[2] = sn % 6;
    dst_p[0] = en / 36;
    dst_p[1] = (en / 6) % 6;
    dst_p[2] = en % 6;
    for (int a = 0; a < 3; a++) begin
      cur_p[a] = src_p[a];
      dir_p[a] = (dst_p[a] > src_p[a]) ? 1 : ((dst_p[a] < src_p[a]) ? -1 : 0);
    end
    run_cells.delete();
    add_cell(cur_p[0], cur_p[1], cur_p[2]);
    if (mode == ModeEdges) begin
      pen_p = cur_p;
      walk_edges(dst_p[0], dst_p[1], dst_p[2]);
    end else begin
      while ((cur_p[0] != dst_p[0] || cur_p[1] != dst_p[1] || cur_p[2] != dst_p[2])
             && run_cells.size() < MaxResults) begin
        prev = cur_p;
        line_step();
        if (cur_p[0] == prev[0] && cur_p[1] == prev[1] && cur_p[2] == prev[2]) break;
        if (mode == ModeYarn) begin
          pen_p = prev;
          walk_edges(cur_p[0], cur_p[1], cur_p[2]);
        end else begin
          add_cell(cur_p[0], cur_p[1], cur_p[2]);
        end
      end
    end
    foreach (run_cells[n]) begin
      pc = '{color: run_cells[n], last: (n == run_cells.size() - 1), bad: 1'b0};
      cell_q.insert(cell_q.size(), pc);
    end
  endfunction

  // request driver: next transaction from the pending queue, predicted on acceptance
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) walk_path(s_axis_tdata);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (request_q.size() > 0 && !roll_idle()) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= request_q.pop_front();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor: random stalls, each transaction checked against the oldest expected cell
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !roll_idle();
      if (m_axis_tvalid && m_axis_tready) begin
        if (cell_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("unexpected cell: index %0d last %0b bad %0b",
                     m_axis_tdata, m_axis_tlast, m_axis_tuser);
        end else begin
          path_cell_t want;
          want = cell_q.pop_front();
          if (want.color !== m_axis_tdata || want.last !== m_axis_tlast
              || want.bad !== m_axis_tuser) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("cell mismatch: expected index %0d last %0b bad %0b, got %0d %0b %0b",
                       want.color, want.last, want.bad,
                       m_axis_tdata, m_axis_tlast, m_axis_tuser);
          end
        end
      end
    end
  end

  function automatic void push_request(input logic [7:0] s_idx, input logic [7:0] e_idx,
                                       input logic [1:0] mode, input logic [2:0] ord);
    request_q.insert(request_q.size(), {3'b000, ord, mode, e_idx, s_idx});
  endfunction

  function automatic logic [7:0] rand_bad_index();
    return $urandom_range(1) ? 8'($urandom_range(15)) : 8'($urandom_range(255, 232));
  endfunction

  // stimulus and end of run
  initial begin
    int pick;
    logic [7:0] s_idx, e_idx;

    // bad indices on either side and at the field extremes
    push_request(8'd0,   8'd100, ModeLine,  OrdRgb);
    push_request(8'd100, 8'd255, ModeYarn,  OrdBgr);
    push_request(8'd15,  8'd232, ModeEdges, OrdGbr);
    push_request(8'd232, 8'd16,  ModeLine,  OrdRgb);
    push_request(8'd255, 8'd0,   2'd3,      3'd7);
    // start equals end
    push_request(8'd16,  8'd16,  ModeLine,  OrdRgb);
    push_request(8'd231, 8'd231, ModeYarn,  OrdBgr);
    push_request(8'd100, 8'd100, ModeEdges, OrdGrb);
    // cube diagonal in every mode and both directions
    push_request(8'd16,  8'd231, ModeLine,  OrdRgb);
    push_request(8'd231, 8'd16,  ModeLine,  OrdRgb);
    push_request(8'd16,  8'd231, ModeYarn,  OrdBrg);
    push_request(8'd231, 8'd16,  ModeEdges, OrdBgr);
    // every axis order, plus the out-of-range orders and walk mode 3
    push_request(8'd22,  8'd201, ModeEdges, OrdRbg);
    push_request(8'd53,  8'd184, ModeYarn,  OrdRbg);
    push_request(8'd184, 8'd53,  ModeYarn,  OrdGrb);
    push_request(8'd40,  8'd155, ModeYarn,  OrdGbr);
    push_request(8'd200, 8'd17,  ModeYarn,  OrdBrg);
    push_request(8'd61,  8'd170, ModeYarn,  OrdBgr);
    push_request(8'd30,  8'd219, ModeYarn,  3'd6);
    push_request(8'd219, 8'd30,  ModeEdges, 3'd7);
    push_request(8'd46,  8'd227, 2'd3,      OrdGrb);
    // lines lying along a face and a single axis
    push_request(8'd16,  8'd51,  ModeLine,  OrdRgb);
    push_request(8'd196, 8'd21,  ModeLine,  OrdRgb);
    push_request(8'd16,  8'd196, ModeYarn,  OrdBgr);

    // random requests, mostly valid paths
    for (int n = 0; n < 350; n++) begin
      pick = $urandom_range(99);
      s_idx = 8'($urandom_range(231, 16));
      e_idx = 8'($urandom_range(231, 16));
      if (pick < 4) begin
        s_idx = rand_bad_index();
      end else if (pick < 8) begin
        e_idx = rand_bad_index();
      end else if (pick < 10) begin
        s_idx = rand_bad_index();
        e_idx = rand_bad_index();
      end else if (pick < 16) begin
        e_idx = s_idx;
      end
      push_request(s_idx, e_idx, 2'($urandom_range(3)), 3'($urandom_range(7)));
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (request_q.size() > 0 || s_axis_tvalid) @(posedge clk_i);
    while (cell_q.size() > 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);

    foreach (cell_q[n]) mismatch_cnt++;
    if (mismatch_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
